/* hdl/maze_backtracker_carver_defines.svh */
// Shared assertion macros for the maze carver.
`ifndef MAZE_BACKTRACKER_CARVER_DEFINES_SVH
`define MAZE_BACKTRACKER_CARVER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MBC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mbc assertion failed");

// Check that a condition is followed by another in the next cycle.
`define MBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbc sequencing assertion failed");

`endif

/* hdl/mbc_pkg.sv */
package mbc_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int CFG_W        = 7;
    localparam int COORD_OUT_W  = 6;

    // Register indexes
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SIDE_RESET = 7'd8;

    // Request codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DRAW  = 1'b1;

    // Direction codes
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic       action;
        logic [1:0] direction;
    } request_t;

    typedef struct packed {
        logic                   carved;
        logic [COORD_OUT_W-1:0] wall_x;
        logic [COORD_OUT_W-1:0] wall_y;
        logic [1:0]             wall_side;
        logic                   finished;
    } result_t;

    // Which row of the visited map to read
    typedef enum logic [1:0] {
        ROW_SEL_STACK = 2'd0,
        ROW_SEL_UP    = 2'd1,
        ROW_SEL_DOWN  = 2'd2
    } row_sel_t;

    typedef struct packed {
        logic     load_start;
        logic     clear_step;
        logic     emit_idle;
        logic     load_draw;
        logic     latch_top;
        logic     latch_row_c;
        logic     latch_row_u;
        logic     latch_row_d;
        logic     decide;
        row_sel_t row_sel;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic stack_empty;
        logic clear_last;
    } status_t;

endpackage

/* hdl/mbc_ram.sv */
module mbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/mbc_ctrl.sv */
`include "maze_backtracker_carver_defines.svh"

module mbc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            action,
    input  mbc_pkg::status_t status,
    output logic            busy,
    output mbc_pkg::cmd_t   cmd
);

    import mbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_TOP,
        S_ROW_C,
        S_ROW_U,
        S_ROW_D,
        S_DECIDE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Decode commands and the next state
    always_comb
    begin
        cmd        = '0;
        cmd.row_sel = ROW_SEL_STACK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_START)
                    begin
                        cmd.load_start = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    else if (status.walk_done || status.stack_empty)
                    begin
                        cmd.emit_idle = 1'b1;
                    end
                    else
                    begin
                        cmd.load_draw = 1'b1;
                        state_next    = S_TOP;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TOP:
            begin
                cmd.latch_top = 1'b1;
                cmd.row_sel   = ROW_SEL_STACK;
                state_next    = S_ROW_C;
            end
            S_ROW_C:
            begin
                cmd.latch_row_c = 1'b1;
                cmd.row_sel     = ROW_SEL_UP;
                state_next      = S_ROW_U;
            end
            S_ROW_U:
            begin
                cmd.latch_row_u = 1'b1;
                cmd.row_sel     = ROW_SEL_DOWN;
                state_next      = S_ROW_D;
            end
            S_ROW_D:
            begin
                cmd.latch_row_d = 1'b1;
                state_next      = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    // Hold state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

    `MBC_ASSERT_NEXT(a_clear_exits, clk, rst_n, state_reg == S_CLEAR && status.clear_last, state_reg == S_IDLE)
    `MBC_ASSERT_NEXT(a_decide_returns, clk, rst_n, state_reg == S_DECIDE, state_reg == S_IDLE && !busy_reg)
    `MBC_ASSERT(a_one_step, clk, rst_n, $onehot0({cmd.clear_step, cmd.latch_top, cmd.latch_row_c, cmd.latch_row_u, cmd.latch_row_d, cmd.decide}))

endmodule

/* hdl/mbc_datapath.sv */
`include "maze_backtracker_carver_defines.svh"

module mbc_datapath #(
    parameter int MAX_SIDE = mbc_pkg::MAX_SIDE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbc_pkg::request_t           request,
    input  mbc_pkg::cmd_t               cmd,
    output mbc_pkg::status_t            status,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [mbc_pkg::CFG_W-1:0]   cfg_data,
    output mbc_pkg::result_t            result,
    output logic                        result_strobe
);

    import mbc_pkg::*;

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int EW    = (SW > CFG_W) ? SW : CFG_W;
    localparam int PW    = 2 * SW;
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int SAW   = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + 1);

    // Configuration and walk state
    logic [CFG_W-1:0] grid_width_reg, grid_height_reg;
    logic [SW-1:0]    cur_w_reg, cur_h_reg;
    logic [PW-1:0]    cells_reg;
    logic [NW-1:0]    depth_reg, depth_next;
    logic [NW-1:0]    total_reg, total_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    clr_cnt_reg;
    logic             strobe_reg, strobe_next;
    result_t          result_reg, result_next;

    // Current draw
    logic [CW-1:0]       x_reg, y_reg;
    logic [1:0]          dir_reg;
    logic [MAX_SIDE-1:0] row_c_reg, row_u_reg, row_d_reg;

    // Memory ports
    logic                row_we;
    logic [CW-1:0]       row_waddr, row_raddr;
    logic [MAX_SIDE-1:0] row_wdata, row_rdata;
    logic                stk_we;
    logic [SAW-1:0]      stk_waddr, stk_raddr;
    logic [2*CW-1:0]     stk_wdata, stk_rdata;

    // Decision terms
    logic [EW-1:0]       w_ext, h_ext;
    logic [SW-1:0]       w_clamp, h_clamp;
    logic [NW-1:0]       depth_m1;
    logic [CW-1:0]       x_m1, x_p1, nx, ny;
    logic                open_up, open_dn, open_lt, open_rt, any_open, move_ok, push;
    logic [MAX_SIDE-1:0] base_row, new_row;

    mbc_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_visited (
        .clk     (clk),
        .wr_en   (row_we),
        .wr_addr (row_waddr),
        .wr_data (row_wdata),
        .rd_addr (row_raddr),
        .rd_data (row_rdata)
    );

    mbc_ram #(.WIDTH(2 * CW), .DEPTH(CELLS)) u_stack (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    // Clamp the grid size taken at start
    always_comb
    begin
        w_ext = EW'(grid_width_reg);
        h_ext = EW'(grid_height_reg);
        if (w_ext < EW'(2))
            w_clamp = SW'(2);
        else if (w_ext > EW'(MAX_SIDE))
            w_clamp = SW'(MAX_SIDE);
        else
            w_clamp = SW'(w_ext);
        if (h_ext < EW'(2))
            h_clamp = SW'(2);
        else if (h_ext > EW'(MAX_SIDE))
            h_clamp = SW'(MAX_SIDE);
        else
            h_clamp = SW'(h_ext);
    end

    // Find open neighbours of the top cell
    always_comb
    begin
        x_m1    = x_reg - CW'(1);
        x_p1    = x_reg + CW'(1);
        open_up = (y_reg != '0) && !row_u_reg[x_reg];
        open_dn = ((SW'(y_reg) + SW'(1)) < cur_h_reg) && !row_d_reg[x_reg];
        open_lt = (x_reg != '0) && !row_c_reg[x_m1];
        open_rt = ((SW'(x_reg) + SW'(1)) < cur_w_reg) && !row_c_reg[x_p1];
        any_open = open_up || open_dn || open_lt || open_rt;
        nx = x_reg;
        ny = y_reg;
        case (dir_reg)
            DIR_UP:
            begin
                move_ok  = open_up;
                ny       = y_reg - CW'(1);
                base_row = row_u_reg;
            end
            DIR_DOWN:
            begin
                move_ok  = open_dn;
                ny       = y_reg + CW'(1);
                base_row = row_d_reg;
            end
            DIR_LEFT:
            begin
                move_ok  = open_lt;
                nx       = x_m1;
                base_row = row_c_reg;
            end
            default:
            begin
                move_ok  = open_rt;
                nx       = x_p1;
                base_row = row_c_reg;
            end
        endcase
        push    = cmd.decide && any_open && move_ok;
        new_row = base_row | (MAX_SIDE'(1) << nx);
    end

    // Drive memory ports
    always_comb
    begin
        depth_m1  = depth_reg - NW'(1);
        stk_raddr = SAW'(depth_m1);
        case (cmd.row_sel)
            ROW_SEL_UP:   row_raddr = y_reg - CW'(1);
            ROW_SEL_DOWN: row_raddr = y_reg + CW'(1);
            default:      row_raddr = stk_rdata[2*CW-1:CW];
        endcase
        row_we    = cmd.clear_step || push;
        row_waddr = cmd.clear_step ? clr_cnt_reg : ny;
        if (cmd.clear_step)
            row_wdata = status.clear_last ? MAX_SIDE'(1) : '0;
        else
            row_wdata = new_row;
        stk_we    = (cmd.clear_step && status.clear_last) || push;
        stk_waddr = cmd.clear_step ? '0 : SAW'(depth_reg);
        stk_wdata = cmd.clear_step ? '0 : {ny, nx};
    end

    assign status.walk_done   = done_reg;
    assign status.stack_empty = (depth_reg == '0);
    assign status.clear_last  = (clr_cnt_reg == '0);

    // Advance the walk and form the result
    always_comb
    begin
        depth_next  = depth_reg;
        total_next  = total_reg;
        done_next   = done_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        if (cmd.load_start)
        begin
            depth_next = '0;
            total_next = '0;
        end
        else if (cmd.clear_step && status.clear_last)
        begin
            depth_next  = NW'(1);
            total_next  = NW'(1);
            done_next   = 1'b0;
            strobe_next = 1'b1;
            result_next = '0;
        end
        else if (cmd.emit_idle)
        begin
            done_next   = 1'b1;
            strobe_next = 1'b1;
            result_next = '0;
            result_next.finished = 1'b1;
        end
        else if (cmd.decide)
        begin
            if (!any_open)
            begin
                depth_next = depth_m1;
                if (depth_m1 == '0)
                    done_next = 1'b1;
            end
            else if (push)
            begin
                depth_next = depth_reg + NW'(1);
                total_next = total_reg + NW'(1);
            end
            if (PW'(total_next) >= cells_reg)
                done_next = 1'b1;
            strobe_next          = 1'b1;
            result_next          = '0;
            result_next.carved   = push;
            result_next.finished = done_next;
            if (push)
            begin
                result_next.wall_x    = COORD_OUT_W'(x_reg);
                result_next.wall_y    = COORD_OUT_W'(y_reg);
                result_next.wall_side = dir_reg;
            end
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= SIDE_RESET;
            grid_height_reg <= SIDE_RESET;
            depth_reg       <= '0;
            total_reg       <= '0;
            done_reg        <= 1'b1;
            strobe_reg      <= 1'b0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    default:         grid_width_reg  <= grid_width_reg;
                endcase
            end
            depth_reg  <= depth_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
            strobe_reg <= strobe_next;
            if (cmd.load_start)
                clr_cnt_reg <= CW'(MAX_SIDE - 1);
            else if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg - CW'(1);
        end
    end

    // Hold payload of the current request
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (cmd.load_start)
        begin
            cur_w_reg <= w_clamp;
            cur_h_reg <= h_clamp;
        end
        if (cmd.clear_step)
            cells_reg <= PW'(cur_w_reg * cur_h_reg);
        if (cmd.load_draw)
            dir_reg <= request.direction;
        if (cmd.latch_top)
        begin
            x_reg <= stk_rdata[CW-1:0];
            y_reg <= stk_rdata[2*CW-1:CW];
        end
        if (cmd.latch_row_c)
            row_c_reg <= row_rdata;
        if (cmd.latch_row_u)
            row_u_reg <= row_rdata;
        if (cmd.latch_row_d)
            row_d_reg <= row_rdata;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    `MBC_ASSERT(a_depth_le_total, clk, rst_n, depth_reg <= total_reg)
    `MBC_ASSERT(a_idle_fields_zero, clk, rst_n, strobe_reg && !result_reg.carved |-> result_reg.wall_x == '0 && result_reg.wall_y == '0 && result_reg.wall_side == '0)
    `MBC_ASSERT(a_carve_depth, clk, rst_n, strobe_reg && result_reg.carved |-> depth_reg >= NW'(2))

endmodule

/* hdl/maze_backtracker_carver.sv */
// Channel   Handshake              Payload
// request   start / busy           request (action, direction)
// result    result_strobe          result (carved, wall_x, wall_y, wall_side, finished)
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A draw goes through these steps from acceptance to its result strobe: one stack read, then
// three reads of the row-wide visited map (own row, row above, row below), then a decide step.
// A draw after the walk has finished gives its result on the next cycle.
// A start clears the visited map one row per cycle and gives its result once the last row
// is cleared. Reset leaves the block idle with the walk marked finished.
// Results are shown for one cycle; the next request may be taken in that same cycle.
module maze_backtracker_carver #(
    parameter int MAX_SIDE = mbc_pkg::MAX_SIDE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  mbc_pkg::request_t         request,
    output mbc_pkg::result_t          result,
    output logic                      result_strobe,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [mbc_pkg::CFG_W-1:0] cfg_data
);

    import mbc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    mbc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    mbc_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

/* bench/mbc_carve_checker.sv */
module mbc_carve_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  mbc_pkg::request_t         request,
    input  mbc_pkg::result_t          result,
    input  logic                      result_strobe,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [mbc_pkg::CFG_W-1:0] cfg_data,
    output int unsigned               mismatches,
    output int unsigned               outstanding
);
    import mbc_pkg::*;

    localparam int SIDE         = MAX_SIDE_DEF;
    localparam int CELLS        = SIDE * SIDE;
    localparam int REPORT_LIMIT = 10;

    // Register copies and the grid size latched at the last start
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      cols;
    int unsigned      rows;

    // Walk state: visited cells, path of open cells, completion flag
    bit               visited [CELLS];
    logic [COORD_OUT_W-1:0] path_x [CELLS];
    logic [COORD_OUT_W-1:0] path_y [CELLS];
    int unsigned      path_depth;
    int unsigned      visited_cells;
    bit               walk_over;

    // Wall reports predicted but not yet seen
    result_t          pending_walls [$];

    function automatic int unsigned clamp_side(input logic [CFG_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > SIDE)
            return SIDE;
        return v;
    endfunction

    // Step from (x,y) toward dir; false when that leaves the grid
    function automatic bit neighbor_of(input int unsigned x, input int unsigned y,
                                       input logic [1:0] dir,
                                       output int unsigned nx, output int unsigned ny);
        nx = x;
        ny = y;
        case (dir)
            DIR_UP:
            begin
                if (y == 0)
                    return 1'b0;
                ny = y - 1;
            end
            DIR_DOWN:
            begin
                if (y + 1 >= rows)
                    return 1'b0;
                ny = y + 1;
            end
            DIR_LEFT:
            begin
                if (x == 0)
                    return 1'b0;
                nx = x - 1;
            end
            default:
            begin
                if (x + 1 >= cols)
                    return 1'b0;
                nx = x + 1;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic bit has_open_neighbor(input int unsigned x, input int unsigned y);
        int unsigned nx;
        int unsigned ny;
        logic [1:0]  d;
        for (int i = 0; i < 4; i++)
        begin
            d = i[1:0];
            if (neighbor_of(x, y, d, nx, ny) && !visited[ny * SIDE + nx])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Mark a cell and push it on the path
    function automatic void visit(input int unsigned x, input int unsigned y);
        visited[y * SIDE + x] = 1'b1;
        visited_cells++;
        if (path_depth < CELLS)
        begin
            path_x[path_depth] = x[COORD_OUT_W-1:0];
            path_y[path_depth] = y[COORD_OUT_W-1:0];
            path_depth++;
        end
    endfunction

    function automatic void clear_walk();
        for (int i = 0; i < CELLS; i++)
            visited[i] = 1'b0;
        path_depth    = 0;
        visited_cells = 0;
    endfunction

    // Advance the walk by one request and return the wall report it causes
    function automatic result_t predict_carve(input request_t req);
        result_t     r;
        int unsigned x;
        int unsigned y;
        int unsigned nx;
        int unsigned ny;
        r = '0;
        if (req.action == ACT_START)
        begin
            cols = clamp_side(width_reg);
            rows = clamp_side(height_reg);
            clear_walk();
            walk_over = 1'b0;
            visit(0, 0);
        end
        else if (!walk_over)
        begin
            if (path_depth == 0)
                walk_over = 1'b1;
            else
            begin
                x = path_x[path_depth - 1];
                y = path_y[path_depth - 1];
                if (!has_open_neighbor(x, y))
                begin
                    // dead end: backtrack one cell
                    path_depth--;
                    if (path_depth == 0)
                        walk_over = 1'b1;
                end
                else if (neighbor_of(x, y, req.direction, nx, ny) &&
                         !visited[ny * SIDE + nx])
                begin
                    r.carved    = 1'b1;
                    r.wall_x    = x[COORD_OUT_W-1:0];
                    r.wall_y    = y[COORD_OUT_W-1:0];
                    r.wall_side = req.direction;
                    visit(nx, ny);
                end
                if (visited_cells >= cols * rows)
                    walk_over = 1'b1;
            end
        end
        r.finished = walk_over;
        return r;
    endfunction

    // Compare one wall report against the oldest prediction
    task automatic check_wall(input result_t got);
        result_t want;
        if (pending_walls.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected wall report carved=%0d x=%0d y=%0d side=%0d fin=%0d",
                         $time, got.carved, got.wall_x, got.wall_y, got.wall_side,
                         got.finished);
        end
        else
        begin
            want = pending_walls.pop_front();
            if (got.carved !== want.carved || got.wall_x !== want.wall_x ||
                got.wall_y !== want.wall_y || got.wall_side !== want.wall_side ||
                got.finished !== want.finished)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: wall report expected carved=%0d x=%0d y=%0d side=%0d fin=%0d, got carved=%0d x=%0d y=%0d side=%0d fin=%0d",
                             $time, want.carved, want.wall_x, want.wall_y,
                             want.wall_side, want.finished, got.carved, got.wall_x,
                             got.wall_y, got.wall_side, got.finished);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = SIDE_RESET;
            height_reg = SIDE_RESET;
            cols       = clamp_side(SIDE_RESET);
            rows       = clamp_side(SIDE_RESET);
            clear_walk();
            walk_over  = 1'b1;
            pending_walls.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // check the report shown this cycle
            if (result_strobe)
                check_wall(result);
            // track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            // predict the report of an accepted request
            if (start && !busy)
                pending_walls.push_back(predict_carve(request));
            outstanding <= pending_walls.size();
        end
    end

endmodule

/* bench/tb.sv */
module tb;
    import mbc_pkg::*;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int DRAW_CAP       = 600;
    localparam int WATCHDOG_LIMIT = 5000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    request_t          request;
    result_t           result;
    logic              result_strobe;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    int unsigned       mismatches;
    int unsigned       outstanding;
    int unsigned       sent_count;
    int unsigned       done_count;
    int unsigned       quiet_cycles;
    bit                walk_complete;
    bit                gaps_on;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    maze_backtracker_carver DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result        (result),
        .result_strobe (result_strobe),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mbc_carve_checker carve_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result        (result),
        .result_strobe (result_strobe),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Count traffic, follow walk completion, and guard against a hang
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_count    <= 0;
            done_count    <= 0;
            quiet_cycles  <= 0;
            walk_complete <= 1'b1;
        end
        else
        begin
            if (start && !busy)
                sent_count <= sent_count + 1;
            if (result_strobe)
                done_count <= done_count + 1;
            if (start && !busy && request.action == ACT_START)
                walk_complete <= 1'b0;
            else if (result_strobe)
                walk_complete <= result.finished;
            if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Mostly small grids, a few extremes and out-of-range values
    function automatic logic [CFG_W-1:0] pick_side();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(2, 8);
        if (r < 86)
            return ($urandom_range(0, 1) != 0) ? 7'd2 : 7'd64;
        if (r < 95)
            return $urandom_range(0, 1);
        return $urandom_range(65, 127);
    endfunction

    task automatic send(input logic act, input logic [1:0] dir);
        int unsigned gap;
        request_t    req;
        gap = pick_gap();
        req.action    = act;
        req.direction = dir;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Hold off until every request has its report
    task automatic wait_results();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sent_count != done_count);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
    endtask

    initial
    begin
        int unsigned useful;
        int unsigned kind;
        int unsigned count;
        int unsigned draws;

        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_GRID_WIDTH;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // undersized registers clamp up to a 2x2 grid
        write_reg(REG_GRID_WIDTH, 7'd0);
        write_reg(REG_GRID_HEIGHT, 7'd1);
        // draw before any start: block stays finished
        send(ACT_DRAW, DIR_UP);
        // walk the 2x2 grid: blocked edges, visited neighbor, then past the end
        send(ACT_START, DIR_RIGHT);
        send(ACT_DRAW, DIR_UP);
        send(ACT_DRAW, DIR_LEFT);
        send(ACT_DRAW, DIR_DOWN);
        send(ACT_DRAW, DIR_UP);
        send(ACT_DRAW, DIR_RIGHT);
        send(ACT_DRAW, DIR_UP);
        send(ACT_DRAW, DIR_DOWN);
        wait_results();

        // oversized registers clamp down to the largest grid
        write_reg(REG_GRID_WIDTH, 7'd127);
        write_reg(REG_GRID_HEIGHT, 7'd127);
        send(ACT_START, DIR_DOWN);
        send(ACT_DRAW, DIR_RIGHT);
        send(ACT_DRAW, DIR_RIGHT);
        send(ACT_DRAW, DIR_DOWN);
        send(ACT_DRAW, DIR_LEFT);
        send(ACT_DRAW, DIR_UP);
        wait_results();

        // new register values wait for the next start
        write_reg(REG_GRID_WIDTH, 7'd64);
        write_reg(REG_GRID_HEIGHT, 7'd2);
        send(ACT_DRAW, DIR_DOWN);
        send(ACT_DRAW, DIR_RIGHT);
        send(ACT_DRAW, DIR_LEFT);
        // restart mid-walk under the new size
        send(ACT_START, DIR_UP);
        send(ACT_DRAW, DIR_LEFT);
        send(ACT_DRAW, DIR_DOWN);
        send(ACT_DRAW, DIR_RIGHT);

        // random phases, each opened from an idle block
        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            wait_results();
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_GRID_WIDTH, pick_side());
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_GRID_HEIGHT, pick_side());
            gaps_on = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                // whole walk: start, then draws until it completes or DRAW_CAP draws are sent
                send(ACT_START, $urandom_range(0, 3));
                useful++;
                draws = 0;
                do
                begin
                    if (!walk_complete)
                        useful++;
                    send(ACT_DRAW, $urandom_range(0, 3));
                    draws++;
                end
                while (!walk_complete && draws < DRAW_CAP);
            end
            else if (kind < 88)
            begin
                // resume the walk in progress under the old latched size
                count = $urandom_range(5, 40);
                repeat (count)
                begin
                    if (!walk_complete)
                        useful++;
                    send(ACT_DRAW, $urandom_range(0, 3));
                end
            end
            else
            begin
                // noise: random starts and draws, walks abandoned early
                count = $urandom_range(4, 20);
                repeat (count)
                begin
                    send($urandom_range(0, 1), $urandom_range(0, 3));
                    useful++;
                end
            end
        end

        wait_results();
        repeat (MAX_SIDE_DEF + 16) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
